// ----- src/bfa_pkg.sv -----
`default_nettype none
// ============================================================================
// bfa_pkg
// Shared types, constants and a helper function for the bitmap allocator.
// ============================================================================
package bfa_pkg;

    localparam int MAP_BYTES       = 1024;
    localparam int INDEX_BYTES_CAP = 1024;
    localparam int WIN_BYTES       = (MAP_BYTES < INDEX_BYTES_CAP) ? MAP_BYTES
                                                                   : INDEX_BYTES_CAP;
    localparam int BITS_PER_WORD   = 8;
    localparam int ROW_BYTES       = 32;
    localparam int ROW_BITS        = ROW_BYTES * BITS_PER_WORD;
    localparam int ROWS            = MAP_BYTES / ROW_BYTES;
    localparam int ROW_AW          = $clog2(ROWS);
    localparam int BYTE_AW         = $clog2(ROW_BYTES);
    localparam int BIT_AW          = $clog2(BITS_PER_WORD);
    localparam int POS_W           = BYTE_AW + BIT_AW;
    localparam int GROUP_SIZE      = 8;
    localparam int GROUPS          = ROW_BYTES / GROUP_SIZE;
    localparam int GROUP_AW        = $clog2(GROUPS);

    localparam int INDEX_W  = 13;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    localparam logic [COUNT_W-1:0]  BYTES_IN_USE_RESET = 11'd1024;
    localparam logic [7:0]          FULL_WORD          = 8'hff;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic REG_BYTES_IN_USE = 1'b0;

    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE        = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } bfa_state_t;

    typedef struct packed {
        logic load;
        logic rd_cur;
        logic step;
        logic finish;
    } bfa_cmd_t;

    typedef struct packed {
        logic scan_done;
    } bfa_sts_t;

    // Position of the lowest set bit of an 8-bit value.
    function automatic logic [2:0] ffs8(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ----- src/bfa_ctrl.sv -----
`default_nettype none
// ============================================================================
// bfa_ctrl
// Request sequencer: accepts a request, steps the row scan and hands the
// result to the output register.
// ============================================================================
module bfa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bfa_pkg::bfa_cmd_t      cmd,
    input  wire bfa_pkg::bfa_sts_t sts
);
    import bfa_pkg::*;

    bfa_state_t state_reg;
    bfa_state_t state_next;
    logic       out_pend_reg;
    logic       out_pend_next;
    logic       out_free;

    assign out_free = !out_pend_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            out_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_pend_reg <= out_pend_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.scan_done && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_READ: begin
                cmd.rd_cur = 1'b1;
            end
            ST_SCAN: begin
                cmd.step   = !sts.scan_done;
                cmd.finish = sts.scan_done && out_free;
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase
        out_pend_next = cmd.finish || (out_pend_reg && out_stall);
    end

    assign out_valid = out_pend_reg;

endmodule
`default_nettype wire

// ----- src/bfa_datapath.sv -----
`default_nettype none
// ============================================================================
// bfa_datapath
// Bitmap RAM of 32-byte rows, row scan logic, free check and result register.
// ============================================================================
module bfa_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bfa_pkg::bfa_cmd_t             cmd,
    output bfa_pkg::bfa_sts_t                  sts,
    input  wire logic                          mode,
    input  wire logic [bfa_pkg::INDEX_W-1:0]   bit_index,
    input  wire logic [bfa_pkg::COUNT_W-1:0]   bytes_in_use,
    output logic      [bfa_pkg::STATUS_W-1:0]  status,
    output logic      [bfa_pkg::INDEX_W-1:0]   allocated_index
);
    import bfa_pkg::*;

    logic [ROW_BITS-1:0] bitmap_mem [ROWS];

    logic                mode_reg;
    logic [INDEX_W-1:0]  bit_index_reg;
    logic [ROW_AW-1:0]   row_cnt_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                rd_zero_reg;
    logic [ROW_AW:0]     fill_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  alloc_idx_reg;

    logic [COUNT_W-1:0]  win_bytes;
    logic                rd_en;
    logic [ROW_AW-1:0]   rd_addr;
    logic [ROW_BITS-1:0] row_q;

    logic [COUNT_W-1:0]  base_ext;
    logic [COUNT_W-1:0]  lim;
    logic [COUNT_W-1:0]  next_base;
    logic                row_end;
    logic [ROW_BYTES-1:0] avail;
    logic [GROUPS-1:0]   grp_any;
    logic [2:0]          grp_idx [GROUPS];
    logic [GROUP_AW-1:0] gsel;
    logic                found;
    logic [BYTE_AW-1:0]  byte_sel;
    logic [7:0]          alloc_byte;
    logic [BIT_AW-1:0]   bit_sel;
    logic [POS_W-1:0]    alloc_pos;

    logic [POS_W-1:0]    free_pos;
    logic [INDEX_W-BIT_AW-1:0] free_word;
    logic                oob;
    logic                bit_set;

    logic [STATUS_W-1:0] status_c;
    logic [INDEX_W-1:0]  idx_c;
    logic                write_ok;
    logic                done;
    logic [ROW_BITS-1:0] wr_data;
    logic                wr_en;

    assign win_bytes = (bytes_in_use > COUNT_W'(WIN_BYTES)) ? COUNT_W'(WIN_BYTES)
                                                            : bytes_in_use;

    assign rd_en   = cmd.rd_cur || cmd.step;
    assign rd_addr = cmd.rd_cur ? row_cnt_reg : row_cnt_reg + ROW_AW'(1);

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= bitmap_mem[rd_addr];
            rd_zero_reg <= ({1'b0, rd_addr} >= fill_reg);
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            bitmap_mem[row_cnt_reg] <= wr_data;
        end
    end

    // Rows at or above the fill count have never been written and read as free.
    assign row_q = rd_zero_reg ? '0 : rd_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fill_reg <= '0;
        end else if (wr_en && ({1'b0, row_cnt_reg} >= fill_reg)) begin
            fill_reg <= {1'b0, row_cnt_reg} + (ROW_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            mode_reg      <= mode;
            bit_index_reg <= bit_index;
            row_cnt_reg   <= (mode == MODE_FREE) ? bit_index[INDEX_W-1 -: ROW_AW] : '0;
        end else if (cmd.step) begin
            row_cnt_reg   <= row_cnt_reg + ROW_AW'(1);
        end
    end

    assign base_ext  = COUNT_W'({row_cnt_reg, {BYTE_AW{1'b0}}});
    assign lim       = (win_bytes > base_ext) ? win_bytes - base_ext : '0;
    assign next_base = COUNT_W'({({1'b0, row_cnt_reg} + (ROW_AW + 1)'(1)),
                                 {BYTE_AW{1'b0}}});
    assign row_end   = (next_base >= win_bytes);

    always_comb begin
        for (int j = 0; j < ROW_BYTES; j++) begin
            avail[j] = (row_q[j*BITS_PER_WORD +: BITS_PER_WORD] != FULL_WORD)
                       && (COUNT_W'(j) < lim);
        end
        for (int g = 0; g < GROUPS; g++) begin
            grp_any[g] = |avail[g*GROUP_SIZE +: GROUP_SIZE];
            grp_idx[g] = ffs8(avail[g*GROUP_SIZE +: GROUP_SIZE]);
        end
        gsel = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                gsel = GROUP_AW'(g);
            end
        end
    end

    assign found      = |grp_any;
    assign byte_sel   = {gsel, grp_idx[gsel]};
    assign alloc_byte = row_q[{byte_sel, {BIT_AW{1'b0}}} +: BITS_PER_WORD];
    assign bit_sel    = ffs8(~alloc_byte);
    assign alloc_pos  = {byte_sel, bit_sel};

    assign free_pos  = bit_index_reg[POS_W-1:0];
    assign free_word = bit_index_reg[INDEX_W-1:BIT_AW];
    assign oob       = ({1'b0, free_word} >= win_bytes);
    assign bit_set   = row_q[free_pos];

    always_comb begin
        status_c = STATUS_OK;
        idx_c    = '0;
        write_ok = 1'b0;
        done     = 1'b0;
        wr_data  = row_q;
        if (mode_reg == MODE_FREE) begin
            done = 1'b1;
            if (oob) begin
                status_c = STATUS_RANGE;
            end else if (!bit_set) begin
                status_c = STATUS_ALREADY_FREE;
            end else begin
                write_ok = 1'b1;
                wr_data  = row_q & ~(ROW_BITS'(1) << free_pos);
            end
        end else begin
            if (found) begin
                done     = 1'b1;
                write_ok = 1'b1;
                wr_data  = row_q | (ROW_BITS'(1) << alloc_pos);
                idx_c    = {row_cnt_reg, alloc_pos};
            end else if (row_end) begin
                done     = 1'b1;
                status_c = STATUS_FULL;
            end
        end
    end

    assign wr_en = cmd.finish && write_ok;

    always_ff @(posedge clk) begin
        if (cmd.finish) begin
            status_reg    <= status_c;
            alloc_idx_reg <= idx_c;
        end
    end

    assign sts.scan_done   = done;
    assign status          = status_reg;
    assign allocated_index = alloc_idx_reg;

endmodule
`default_nettype wire

// ----- src/bitmap_free_bit_allocator.sv -----
`default_nettype none
// ============================================================================
// bitmap_free_bit_allocator
// First-zero bitmap allocator with an APB-style window size register.
// ============================================================================
// A request passes through the idle, read and scan states. A free request checks
// and clears its bit in the first row read; an allocate scans the 32-byte rows in
// order (1 to 32 rows), one row per cycle from the single-port bitmap RAM.
// The next request is taken only once the previous result is handed to the output.
// After reset the whole bitmap reads as free through a count of rows written,
// without a clearing pass, and bytes_in_use is 1024.
module bitmap_free_bit_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          mode,
    input  wire logic [bfa_pkg::INDEX_W-1:0]   bit_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [bfa_pkg::STATUS_W-1:0]  status,
    output logic      [bfa_pkg::INDEX_W-1:0]   allocated_index,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bfa_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bfa_pkg::DATA_W-1:0]    pwdata,
    output logic      [bfa_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);
    import bfa_pkg::*;

    logic [COUNT_W-1:0] bytes_in_use_reg;
    logic               cfg_wr;
    bfa_cmd_t           cmd;
    bfa_sts_t           sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1] == REG_BYTES_IN_USE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bytes_in_use_reg <= BYTES_IN_USE_RESET;
        end else if (cfg_wr) begin
            bytes_in_use_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1] == REG_BYTES_IN_USE) ? DATA_W'(bytes_in_use_reg)
                                                           : '0;

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    bfa_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .mode            (mode),
        .bit_index       (bit_index),
        .bytes_in_use    (bytes_in_use_reg),
        .status          (status),
        .allocated_index (allocated_index)
    );

endmodule
`default_nettype wire

// ----- src/bfa_checker.sv -----
`default_nettype none
// ============================================================================
// bfa_checker
// Port-level checks on request and result ordering of the allocator.
// ============================================================================
module bfa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [bfa_pkg::STATUS_W-1:0]  status,
    input wire logic [bfa_pkg::INDEX_W-1:0]   allocated_index
);
    import bfa_pkg::*;

    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("request accepted while the previous one is still in work");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result shown without an outstanding request");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> allocated_index == '0)
        else $error("nonzero index returned with an error status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
                                   && $stable(allocated_index))
        else $error("stalled result changed");

endmodule

bind bitmap_free_bit_allocator bfa_checker u_bfa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .allocated_index (allocated_index)
);
`default_nettype wire

// ----- sim/bitmap_free_bit_allocator_tb.sv -----
// ============================================================================
// bitmap_free_bit_allocator_tb
// Self-checking testbench for the first-zero bitmap allocator. A mirror of the
// bitmap predicts every allocate and free request, and each result is compared
// in order. The run uses a directed opening, then random phases under several
// window sizes with random gaps on both channels.
// ============================================================================
module bitmap_free_bit_allocator_tb;
    import bfa_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
    } grant_t;

    class bitmap_mirror;
        bit [7:0]    words [MAP_BYTES];
        int unsigned bytes_in_use;
        int unsigned top_word;
        grant_t      pending_grants[$];
        int          errors;
        int          status_seen[4];

        function new();
            foreach (words[i]) words[i] = '0;
            bytes_in_use = BYTES_IN_USE_RESET;
            top_word = 0;
            errors = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned window_bytes();
            int unsigned n;
            n = bytes_in_use;
            if (n > MAP_BYTES) n = MAP_BYTES;
            if (n > INDEX_BYTES_CAP) n = INDEX_BYTES_CAP;
            return n;
        endfunction

        function void report(string what, int exp_val, int act_val);
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, what, exp_val, act_val);
        endfunction

        function void note_request(logic req_mode, logic [INDEX_W-1:0] idx);
            grant_t      g;
            int unsigned n;
            int unsigned w;
            int unsigned b;
            n = window_bytes();
            g.status = STATUS_OK;
            g.index = '0;
            if (req_mode == MODE_ALLOC) begin
                w = 0;
                while (w < n && words[w] == FULL_WORD) w++;
                if (w >= n) begin
                    g.status = STATUS_FULL;
                end
                else begin
                    b = 0;
                    while (words[w][b]) b++;
                    words[w][b] = 1'b1;
                    g.index = INDEX_W'(w * BITS_PER_WORD + b);
                    if (w + 1 > top_word) top_word = w + 1;
                end
            end
            else begin
                w = idx / BITS_PER_WORD;
                b = idx % BITS_PER_WORD;
                if (w >= n)
                    g.status = STATUS_RANGE;
                else if (!words[w][b])
                    g.status = STATUS_ALREADY_FREE;
                else
                    words[w][b] = 1'b0;
            end
            pending_grants.push_back(g);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] idx);
            grant_t g;
            if (pending_grants.size() == 0) begin
                report("result with no request outstanding, status", -1, st);
                return;
            end
            g = pending_grants.pop_front();
            status_seen[g.status]++;
            if (st !== g.status)
                report("status", g.status, st);
            if (idx !== g.index)
                report("allocated_index", g.index, idx);
        endfunction

        function logic [INDEX_W-1:0] pick_taken();
            int unsigned n;
            int unsigned w;
            int unsigned b;
            n = window_bytes();
            if (top_word < n) n = top_word;
            if (n == 0) return INDEX_W'($urandom_range(0, 8191));
            w = 0;
            repeat (8) begin
                w = $urandom_range(0, n - 1);
                if (words[w] != 0) begin
                    b = $urandom_range(0, 7);
                    while (!words[w][b]) b = (b + 1) % BITS_PER_WORD;
                    return INDEX_W'(w * BITS_PER_WORD + b);
                end
            end
            return INDEX_W'(w * BITS_PER_WORD + $urandom_range(0, 7));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                mode = MODE_ALLOC;
    logic [INDEX_W-1:0]  bit_index = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  allocated_index;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    bitmap_mirror mirror = new();
    bit           src_pauses = 1'b0;
    bit           sink_pauses = 1'b0;
    int           stall_left = 0;
    int           requests_sent = 0;
    int           windows_used = 0;

    bitmap_free_bit_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .bit_index       (bit_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .allocated_index (allocated_index),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || !sink_pauses) begin
            stall_left <= 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            mirror.check_result(status, allocated_index);
    end

    task automatic send_request(input logic req_mode, input logic [INDEX_W-1:0] idx);
        in_valid <= 1'b1;
        mode <= req_mode;
        bit_index <= idx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        mirror.note_request(req_mode, idx);
        requests_sent++;
        if (src_pauses && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending_grants.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(input int unsigned value);
        logic [DATA_W-1:0] wdata;
        drain();
        wdata = $urandom;
        wdata[COUNT_W-1:0] = COUNT_W'(value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(REG_BYTES_IN_USE));
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        mirror.bytes_in_use = value;
        windows_used++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== DATA_W'(value))
            mirror.report("bytes_in_use readback", value, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int alloc_pct);
        int unsigned n;
        int          c;
        for (int i = 0; i < count; i++) begin
            n = mirror.window_bytes();
            c = $urandom_range(0, 19);
            if ($urandom_range(0, 99) < alloc_pct)
                send_request(MODE_ALLOC, INDEX_W'($urandom_range(0, 8191)));
            else if (c < 14)
                send_request(MODE_FREE, mirror.pick_taken());
            else if (c < 17 || n == 0)
                send_request(MODE_FREE, INDEX_W'($urandom_range(0, 8191)));
            else
                send_request(MODE_FREE, INDEX_W'(n * BITS_PER_WORD - 1 + $urandom_range(0, 1)));
            if (src_pauses && $urandom_range(0, 149) == 0)
                drain();
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("bitmap_free_bit_allocator: mismatch");
        $finish;
    end

    initial
    begin
        int          remaining;
        int          len;
        int          pick;
        int unsigned win;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '1);
        send_request(MODE_ALLOC, INDEX_W'(4660));
        send_request(MODE_FREE, INDEX_W'(1));
        send_request(MODE_FREE, INDEX_W'(1));
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, INDEX_W'(8191));
        send_request(MODE_FREE, INDEX_W'(0));
        set_window(0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, INDEX_W'(0));
        set_window(1);
        repeat (7) send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, INDEX_W'(8));
        send_request(MODE_FREE, INDEX_W'(5));
        send_request(MODE_ALLOC, '0);
        set_window(2047);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, INDEX_W'(7));

        remaining = 1750;
        while (remaining > 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: win = 0;
                1: win = 1024;
                2: win = 2047;
                3: win = $urandom_range(1025, 2047);
                4: win = $urandom_range(9, 1023);
                default: win = $urandom_range(1, 6);
            endcase
            set_window(win);
            if (remaining <= 250) begin
                src_pauses = 1'b0;
                sink_pauses = 1'b0;
                len = remaining;
            end
            else begin
                src_pauses = $urandom_range(0, 3) != 0;
                sink_pauses = $urandom_range(0, 3) != 0;
                len = $urandom_range(60, 160);
                if (remaining - len < 200) len = remaining - 200;
            end
            random_phase(len, $urandom_range(30, 75));
            remaining -= len;
        end

        drain();
        repeat (40) @(posedge clk);
        $display("Ran %0d requests across %0d window settings: %0d ok, %0d full,",
                 requests_sent, windows_used, mirror.status_seen[STATUS_OK],
                 mirror.status_seen[STATUS_FULL]);
        $display("%0d out of range and %0d already free.",
                 mirror.status_seen[STATUS_RANGE], mirror.status_seen[STATUS_ALREADY_FREE]);
        if (mirror.errors == 0 && mirror.pending_grants.size() == 0)
            $display("bitmap_free_bit_allocator: match");
        else
            $display("bitmap_free_bit_allocator: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/bfa_pkg.sv
src/bfa_ctrl.sv
src/bfa_datapath.sv
src/bitmap_free_bit_allocator.sv
src/bfa_checker.sv
sim/bitmap_free_bit_allocator_tb.sv
